// ===== hw/rtl/ernn_pkg.sv =====
package ernn_pkg;

	localparam int MaxFeatures = 16;
	localparam int MaxHidden   = 16;
	localparam int DataWidth   = 16;
	localparam int FracBits    = 12;
	localparam int AccWidth    = 40;
	localparam int FeatBits    = $clog2(MaxFeatures);
	localparam int HidBits     = $clog2(MaxHidden);
	localparam int WAddrBits   = FeatBits + HidBits;
	localparam int RAddrBits   = 2 * HidBits;

	// operation codes
	localparam logic [1:0] OpInWeight  = 2'd0;
	localparam logic [1:0] OpRecWeight = 2'd1;
	localparam logic [1:0] OpBias      = 2'd2;
	localparam logic [1:0] OpFeature   = 2'd3;

	// activation codes
	localparam logic [1:0] ActTanh     = 2'd0;
	localparam logic [1:0] ActSigmoid  = 2'd1;
	localparam logic [1:0] ActRelu     = 2'd2;
	localparam logic [1:0] ActIdentity = 2'd3;

	// config register indexes
	localparam logic [1:0] RegActivation = 2'd0;
	localparam logic [1:0] RegHiddenCnt  = 2'd1;
	localparam logic [1:0] RegEmitEvery  = 2'd2;
	localparam logic [1:0] RegEmitDeriv  = 2'd3;

	// tanh of |x| in Q.12 at quarter steps from 0 to 4
	function automatic logic [11:0] tanh_lut(input logic [4:0] i);
		case (i)
			5'd0:  tanh_lut = 12'd0;
			5'd1:  tanh_lut = 12'd1003;
			5'd2:  tanh_lut = 12'd1893;
			5'd3:  tanh_lut = 12'd2602;
			5'd4:  tanh_lut = 12'd3119;
			5'd5:  tanh_lut = 12'd3475;
			5'd6:  tanh_lut = 12'd3707;
			5'd7:  tanh_lut = 12'd3856;
			5'd8:  tanh_lut = 12'd3949;
			5'd9:  tanh_lut = 12'd4006;
			5'd10: tanh_lut = 12'd4041;
			5'd11: tanh_lut = 12'd4062;
			5'd12: tanh_lut = 12'd4076;
			5'd13: tanh_lut = 12'd4084;
			5'd14: tanh_lut = 12'd4089;
			5'd15: tanh_lut = 12'd4091;
			default: tanh_lut = 12'd4093;
		endcase
	endfunction

	// saturate a signed 40 bit value to the data range
	function automatic logic signed [DataWidth-1:0] sat40(input logic signed [AccWidth-1:0] v);
		logic signed [AccWidth-1:0] hi;
		logic signed [AccWidth-1:0] lo;
		hi = AccWidth'((1 <<< (DataWidth - 1)) - 1);
		lo = -hi - AccWidth'(1);
		if (v > hi) sat40 = hi[DataWidth-1:0];
		else if (v < lo) sat40 = lo[DataWidth-1:0];
		else sat40 = v[DataWidth-1:0];
	endfunction

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_FEAT  = 8'b00000010,
		ST_BIAS  = 8'b00000100,
		ST_REC   = 8'b00001000,
		ST_ACT   = 8'b00010000,
		ST_DER   = 8'b00100000,
		ST_EMIT  = 8'b01000000,
		ST_WAIT  = 8'b10000000
	} state_t;

endpackage

// ===== hw/rtl/elman_rnn_cell_forward.sv =====
// Elman cell forward pass in Q4.12. A load transaction (weight, bias) is written
// to its memory as it is taken, and the block stays ready. A feature transaction
// walks the hidden units in use through one shared multiply-accumulate unit, each
// unit in a fetch and then an accumulate step. The closing feature then runs, per
// unit, a bias add, a recurrent product for each unit in use (skipped on the
// first step), an activation step and a derivative step. All of this is bound
// by the single MAC and the single read port of each weight memory. Results
// leave through an output register one unit at a time, the next only once the
// receiver has taken the last; the block takes no new transaction until the
// step is done and any emission of it is complete.
module elman_rnn_cell_forward (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [4:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [3:0]        row,
	input  logic [3:0]        col,
	input  logic signed [15:0] value,
	input  logic              first_step,
	input  logic              last_feature,
	input  logic              last_step,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        unit_index,
	output logic signed [15:0] hidden_value,
	output logic signed [15:0] derivative,
	output logic              last
);

	localparam int AW = ernn_pkg::AccWidth;
	localparam int RW = ernn_pkg::AccWidth + 1;
	localparam int DW = ernn_pkg::DataWidth;
	localparam int HB = ernn_pkg::HidBits;

	// configuration registers
	logic [1:0] act_q;
	logic [4:0] hcnt_q;
	logic       every_q;
	logic       deriv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= ernn_pkg::ActTanh;
			hcnt_q  <= 5'd16;
			every_q <= 1'b1;
			deriv_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ernn_pkg::RegActivation: act_q   <= cfg_data[1:0];
				ernn_pkg::RegHiddenCnt:  hcnt_q  <= cfg_data;
				ernn_pkg::RegEmitEvery:  every_q <= cfg_data[0];
				ernn_pkg::RegEmitDeriv:  deriv_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// units in use minus one
	logic [HB-1:0] hlast;
	always_comb begin
		if (hcnt_q == 5'd0) hlast = '0;
		else if (hcnt_q > 5'(ernn_pkg::MaxHidden)) hlast = HB'(ernn_pkg::MaxHidden - 1);
		else hlast = HB'(hcnt_q - 5'd1);
	end

	ernn_pkg::state_t st_q;
	logic [HB-1:0] j_q, k_q;
	logic [3:0] row_q;
	logic signed [15:0] x_q;
	logic first_q, lastf_q, emit_q;
	logic signed [AW-1:0] sum_q;
	logic signed [DW-1:0] y_q;
	logic [1:0] phase_q;

	// memories
	logic we_in, we_rec, we_b;
	logic [ernn_pkg::WAddrBits-1:0] in_raddr;
	logic [ernn_pkg::RAddrBits-1:0] rec_raddr;
	logic [15:0] win_rd, wrec_rd, b_rd;
	logic accept;

	assign accept = in_valid && in_ready;
	assign we_in  = accept && op == ernn_pkg::OpInWeight;
	assign we_rec = accept && op == ernn_pkg::OpRecWeight;
	assign we_b   = accept && op == ernn_pkg::OpBias;

	ernn_ram #(.Width(16), .Depth(ernn_pkg::MaxFeatures * ernn_pkg::MaxHidden)) u_win (
		.clk(clk), .we(we_in), .waddr({row, col}), .wdata(value),
		.raddr(in_raddr), .rdata(win_rd));
	ernn_ram #(.Width(16), .Depth(ernn_pkg::MaxHidden * ernn_pkg::MaxHidden)) u_wrec (
		.clk(clk), .we(we_rec), .waddr({row, col}), .wdata(value),
		.raddr(rec_raddr), .rdata(wrec_rd));
	ernn_ram #(.Width(16), .Depth(ernn_pkg::MaxHidden)) u_bias (
		.clk(clk), .we(we_b), .waddr(col), .wdata(value),
		.raddr(j_q), .rdata(b_rd));

	// accumulators and previous hidden, each read at a walking index
	logic signed [AW-1:0] acc_q [ernn_pkg::MaxHidden];
	logic [ernn_pkg::MaxHidden-1:0] hvalid_q;
	logic signed [DW-1:0] hprev_q [ernn_pkg::MaxHidden];
	logic signed [DW-1:0] hnew_q [ernn_pkg::MaxHidden];

	assign in_raddr  = {row_q, j_q};
	assign rec_raddr = {k_q, j_q};

	// shared multiply-accumulate
	logic signed [15:0] ma, mb;
	logic signed [31:0] prod;
	logic signed [DW-1:0] hp_k;
	assign hp_k = hprev_q[k_q];
	always_comb begin
		ma = x_q;
		mb = $signed(win_rd);
		case (st_q)
			ernn_pkg::ST_REC: begin
				ma = hp_k;
				mb = $signed(wrec_rd);
			end
			ernn_pkg::ST_DER: begin
				ma = y_q;
				mb = (act_q == ernn_pkg::ActTanh) ? y_q : 16'(17'sd4096 - 17'(y_q));
			end
			default: ;
		endcase
		prod = ma * mb;
	end

	// activation from rounded sum
	logic signed [RW-1:0] rnd;
	logic signed [DW-1:0] xs;
	logic [16:0] mag;
	logic [4:0] idx;
	logic [10:0] rem;
	logic [11:0] t0, t1, dq;
	logic [23:0] dr;
	logic [12:0] tq;
	logic signed [DW-1:0] yact;
	logic signed [17:0] sg;
	always_comb begin
		// one guard bit so the rounding add cannot wrap
		rnd = (RW'(sum_q) + RW'(1 <<< (ernn_pkg::FracBits - 1))) >>> ernn_pkg::FracBits;
		xs = ernn_pkg::sat40(rnd[AW-1:0]);
		mag = xs[DW-1] ? 17'(-18'(xs)) : 17'(xs);
		if (act_q == ernn_pkg::ActTanh) begin
			idx = (mag[16:10] >= 7'd16) ? 5'd16 : 5'(mag[16:10]);
			rem = {1'b0, mag[9:0]};
		end else begin
			idx = (mag[16:11] >= 6'd16) ? 5'd16 : 5'(mag[16:11]);
			rem = mag[10:0];
		end
		t0 = ernn_pkg::tanh_lut(idx);
		t1 = ernn_pkg::tanh_lut((idx == 5'd16) ? 5'd16 : idx + 5'd1);
		dq = t1 - t0;
		dr = dq * 24'(rem);
		if (idx == 5'd16) tq = 13'(t0);
		else if (act_q == ernn_pkg::ActTanh) tq = 13'(t0) + 13'(dr >> 10);
		else tq = 13'(t0) + 13'(dr >> 11);
		sg = xs[DW-1] ? -18'(tq) : 18'(tq);
		case (act_q)
			ernn_pkg::ActTanh:    yact = 16'(sg);
			ernn_pkg::ActSigmoid: yact = 16'((18'sd4096 + sg + 18'sd1) >>> 1);
			ernn_pkg::ActRelu:    yact = xs[DW-1] ? '0 : xs;
			default:              yact = xs;
		endcase
	end

	// derivative from product
	logic signed [32:0] pr;
	logic signed [AW-1:0] dtmp;
	logic signed [DW-1:0] dval;
	always_comb begin
		pr = (33'(prod) + 33'sd2048) >>> 12;
		case (act_q)
			ernn_pkg::ActTanh:    dtmp = AW'(4096) - AW'(pr);
			ernn_pkg::ActSigmoid: dtmp = AW'(pr);
			ernn_pkg::ActRelu:    dtmp = (y_q > 0) ? AW'(4096) : '0;
			default:              dtmp = AW'(4096);
		endcase
		dval = ernn_pkg::sat40(dtmp);
	end

	assign in_ready = st_q == ernn_pkg::ST_IDLE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ernn_pkg::ST_IDLE;
			j_q <= '0;
			k_q <= '0;
			phase_q <= '0;
			hvalid_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < ernn_pkg::MaxHidden; i++) begin
				acc_q[i] <= '0;
				hprev_q[i] <= '0;
				hnew_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ernn_pkg::ST_IDLE: begin
					if (accept && op == ernn_pkg::OpFeature) begin
						row_q <= row;
						x_q <= value;
						first_q <= first_step;
						lastf_q <= last_feature;
						emit_q <= every_q || last_step;
						j_q <= '0;
						phase_q <= '0;
						st_q <= ernn_pkg::ST_FEAT;
					end
				end
				ernn_pkg::ST_FEAT: begin
					// phase 0 fetches, phase 1 accumulates
					if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
					end else begin
						acc_q[j_q] <= acc_q[j_q] + AW'(prod);
						if (j_q == hlast) begin
							j_q <= '0;
							phase_q <= '0;
							st_q <= lastf_q ? ernn_pkg::ST_BIAS : ernn_pkg::ST_IDLE;
						end else begin
							j_q <= j_q + 1'b1;
							phase_q <= 2'd0;
						end
					end
				end
				ernn_pkg::ST_BIAS: begin
					if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
					end else begin
						sum_q <= acc_q[j_q] + (AW'($signed(b_rd)) <<< ernn_pkg::FracBits);
						k_q <= '0;
						phase_q <= '0;
						st_q <= first_q ? ernn_pkg::ST_ACT : ernn_pkg::ST_REC;
					end
				end
				ernn_pkg::ST_REC: begin
					if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
					end else begin
						sum_q <= sum_q + AW'(prod);
						phase_q <= '0;
						if (k_q == hlast) st_q <= ernn_pkg::ST_ACT;
						else k_q <= k_q + 1'b1;
					end
				end
				ernn_pkg::ST_ACT: begin
					y_q <= yact;
					st_q <= ernn_pkg::ST_DER;
				end
				ernn_pkg::ST_DER: begin
					hnew_q[j_q] <= y_q;
					acc_q[j_q] <= '0;
					if (j_q == hlast) begin
						j_q <= '0;
						for (int i = 0; i < ernn_pkg::MaxHidden; i++) begin
							if (HB'(i) == j_q) hprev_q[i] <= y_q;
							else hprev_q[i] <= hnew_q[i];
						end
						st_q <= emit_q ? ernn_pkg::ST_EMIT : ernn_pkg::ST_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
						st_q <= ernn_pkg::ST_BIAS;
					end
				end
				ernn_pkg::ST_EMIT: begin
					out_valid <= 1'b1;
					unit_index <= 4'(j_q);
					hidden_value <= hprev_q[j_q];
					last <= j_q == hlast;
					st_q <= ernn_pkg::ST_WAIT;
				end
				ernn_pkg::ST_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (j_q == hlast) begin
							j_q <= '0;
							st_q <= ernn_pkg::ST_IDLE;
						end else begin
							j_q <= j_q + 1'b1;
							st_q <= ernn_pkg::ST_EMIT;
						end
					end
				end
				default: st_q <= ernn_pkg::ST_IDLE;
			endcase
			hvalid_q <= '1;
		end
	end

	// derivatives of the step, kept beside the hidden values
	logic signed [DW-1:0] dstore_q [ernn_pkg::MaxHidden];
	always_ff @(posedge clk) begin
		if (st_q == ernn_pkg::ST_DER) dstore_q[j_q] <= dval;
		if (st_q == ernn_pkg::ST_EMIT)
			derivative <= (deriv_q && hvalid_q[j_q]) ? dstore_q[j_q] : '0;
	end

endmodule

// ===== hw/rtl/ernn_ram.sv =====
module ernn_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
